[design/ubxd_pkg.sv]
`default_nettype none

package ubxd_pkg;

    localparam int BYTE_W     = 8;
    localparam int SKIP_W     = 32;
    localparam int BODY_W     = 17;
    localparam int HDR_IDX_W  = 2;
    localparam int STATUS_W   = 2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

    // header byte positions
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LOW  = 2'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HIGH = 2'd3;

    localparam logic [BODY_W-1:0] CHECKSUM_BYTES = 17'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_BUSY      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLEAN_END = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                out_valid;
        logic                frame_start;
        logic                frame_last;
        logic [SKIP_W-1:0]   discarded_count;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

[design/ubxd_ifs.sv]
`default_nettype none

// Byte channel into the deframer
interface ubxd_rx_if import ubxd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              stream_end;

    modport source (output valid, rx_byte, stream_end, input ready);
    modport sink   (input valid, rx_byte, stream_end, output ready);
endinterface

// Result channel out of the deframer
interface ubxd_tx_if import ubxd_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                out_valid;
    logic                frame_start;
    logic                frame_last;
    logic [SKIP_W-1:0]   discarded_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, out_byte, out_valid, frame_start, frame_last,
                    discarded_count, status, input ready);
    modport sink   (input valid, out_byte, out_valid, frame_start, frame_last,
                    discarded_count, status, output ready);
endinterface

`default_nettype wire

[design/ubxd_core.sv]
`default_nettype none

// Sync hunt and frame tracking; result is combinational from state and byte
module ubxd_core import ubxd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              stream_end,
    output result_t                res
);

    typedef enum logic [1:0] {
        PH_SEEK   = 2'd0,
        PH_SYNC1  = 2'd1,
        PH_HEADER = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    phase_t               phase_reg,          phase_next;
    logic [HDR_IDX_W-1:0] header_index_reg,   header_index_next;
    logic [BYTE_W-1:0]    length_low_reg,     length_low_next;
    logic [BODY_W-1:0]    body_remaining_reg, body_remaining_next;
    logic [SKIP_W-1:0]    skip_count_reg,     skip_count_next;

    logic [SKIP_W-1:0] skip_plus1;
    logic [SKIP_W-1:0] skip_plus2;

    // saturating skip increments
    always_comb
    begin
        skip_plus1 = (&skip_count_reg) ? skip_count_reg : skip_count_reg + 1'b1;
        skip_plus2 = (&skip_count_reg[SKIP_W-1:1]) ? {SKIP_W{1'b1}}
                                                   : skip_count_reg + 2'd2;
    end

    // next state and result
    always_comb
    begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        length_low_next     = length_low_reg;
        body_remaining_next = body_remaining_reg;
        skip_count_next     = skip_count_reg;
        res                 = '0;
        res.status          = STATUS_BUSY;

        if (stream_end)
        begin
            res.status          = (phase_reg == PH_SEEK) ? STATUS_CLEAN_END
                                                         : STATUS_TRUNCATED;
            phase_next          = PH_SEEK;
            header_index_next   = '0;
            length_low_next     = '0;
            body_remaining_next = '0;
            skip_count_next     = '0;
        end
        else
        begin
            case (phase_reg)
                PH_SEEK:
                begin
                    if (rx_byte == SYNC_FIRST)
                        phase_next = PH_SYNC1;
                    else
                        skip_count_next = skip_plus1;
                end
                PH_SYNC1:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        res.frame_start     = 1'b1;
                        res.discarded_count = skip_count_reg;
                        skip_count_next     = '0;
                        header_index_next   = '0;
                        phase_next          = PH_HEADER;
                    end
                    else if (rx_byte == SYNC_FIRST)
                    begin
                        // held sync byte skipped, new one kept
                        skip_count_next = skip_plus1;
                    end
                    else
                    begin
                        skip_count_next = skip_plus2;
                        phase_next      = PH_SEEK;
                    end
                end
                PH_HEADER:
                begin
                    res.out_byte  = rx_byte;
                    res.out_valid = 1'b1;
                    if (header_index_reg == HDR_LEN_LOW)
                        length_low_next = rx_byte;
                    if (header_index_reg == HDR_LEN_HIGH)
                    begin
                        body_remaining_next = {1'b0, rx_byte, length_low_reg}
                                              + CHECKSUM_BYTES;
                        header_index_next   = '0;
                        phase_next          = PH_BODY;
                    end
                    else
                    begin
                        header_index_next = header_index_reg + 1'b1;
                    end
                end
                PH_BODY:
                begin
                    res.out_byte  = rx_byte;
                    res.out_valid = 1'b1;
                    if (body_remaining_reg <= BODY_W'(1))
                    begin
                        res.frame_last      = 1'b1;
                        res.status          = STATUS_COMPLETE;
                        phase_next          = PH_SEEK;
                        header_index_next   = '0;
                        length_low_next     = '0;
                        body_remaining_next = '0;
                        skip_count_next     = '0;
                    end
                    else
                    begin
                        body_remaining_next = body_remaining_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_SEEK;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_SEEK;
            header_index_reg   <= '0;
            length_low_reg     <= '0;
            body_remaining_reg <= '0;
            skip_count_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            length_low_reg     <= length_low_next;
            body_remaining_reg <= body_remaining_next;
            skip_count_reg     <= skip_count_next;
        end
    end

    // checks
    a_start_enters_header: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.frame_start |=> phase_reg == PH_HEADER && skip_count_reg == '0)
        else $error("sync pair did not enter header phase");

    a_last_is_complete: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.frame_last |=> phase_reg == PH_SEEK && body_remaining_reg == '0)
        else $error("frame end did not restart hunt");

    a_body_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_BODY |-> body_remaining_reg == '0)
        else $error("body count live outside body phase");

    a_body_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> body_remaining_reg != '0)
        else $error("body phase with nothing due");

endmodule

`default_nettype wire

[design/ubxd_out_stage.sv]
`default_nettype none

// Result register; takes a new result whenever it is empty or being drained
module ubxd_out_stage import ubxd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  result_t     d,
    output logic        space,
    ubxd_tx_if.source   tx
);

    logic    valid_reg;
    result_t data_reg;

    assign space = !valid_reg || tx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (tx.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= d;
    end

    assign tx.valid           = valid_reg;
    assign tx.out_byte        = data_reg.out_byte;
    assign tx.out_valid       = data_reg.out_valid;
    assign tx.frame_start     = data_reg.frame_start;
    assign tx.frame_last      = data_reg.frame_last;
    assign tx.discarded_count = data_reg.discarded_count;
    assign tx.status          = data_reg.status;

endmodule

`default_nettype wire

[design/ubx_frame_deframer.sv]
`default_nettype none

// Channel  Dir  Payload                                              Transaction
// rx       in   rx_byte[7:0], stream_end                             valid & ready
// tx       out  out_byte, out_valid, frame_start, frame_last,        valid & ready
//               discarded_count[31:0], status[1:0]
//
// One result per byte; one transaction per cycle sustained while tx does not stall.
// The state update and result are formed in the cycle the byte is taken and
// the result register shows them on the next edge.
// Reset clears the hunt state and empties the result register.
// rx.ready stays high while the result register is empty or being drained,
// so a stall on tx holds at most one result and backs up rx.
module ubx_frame_deframer import ubxd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ubxd_rx_if.sink   rx,
    ubxd_tx_if.source tx
);

    logic    space;
    logic    accept;
    result_t res;

    assign rx.ready = space;
    assign accept   = rx.valid && space;

    ubxd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .rx_byte    (rx.rx_byte),
        .stream_end (rx.stream_end),
        .res        (res)
    );

    ubxd_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .d     (res),
        .space (space),
        .tx    (tx)
    );

endmodule

`default_nettype wire
